[hdl/dbs_pkg.sv]
// Package for the decimal bucket sorter: sizes, span table and FSM codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dbs_pkg;
  localparam int MaxItems   = 64;
  localparam int ValueBits  = 32;
  localparam int IdxBits    = $clog2(MaxItems);
  localparam int CntBits    = $clog2(MaxItems + 1);
  localparam int NumBuckets = 10;
  localparam int BktBits    = 4;
  localparam int NumSteps   = 10;

  // bucket step sizes: 1, 10, ... 10^9
  function automatic logic [31:0] step_of(input logic [3:0] k);
    logic [31:0] s;
    s = 32'd1;
    case (k)
      4'd0: s = 32'd1;
      4'd1: s = 32'd10;
      4'd2: s = 32'd100;
      4'd3: s = 32'd1000;
      4'd4: s = 32'd10000;
      4'd5: s = 32'd100000;
      4'd6: s = 32'd1000000;
      4'd7: s = 32'd10000000;
      4'd8: s = 32'd100000000;
      4'd9: s = 32'd1000000000;
      default: s = 32'd1;
    endcase
    return s;
  endfunction

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_SPAN  = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_KEY   = 8'b0000_1000,
    ST_CMP   = 8'b0001_0000,
    ST_WR    = 8'b0010_0000,
    ST_ORD   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

[hdl/dbs_bucketer.sv]
// Shared compare unit: bucket index of a value given the bucket step.
// Depends on dbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbs_bucketer import dbs_pkg::*; (
  input  wire logic [ValueBits-1:0] value,
  input  wire logic [3:0]           step_idx,
  output logic [BktBits-1:0]        bucket
);
  // value / step clipped to 9: count multiples of step not above value
  logic [35:0] mult [1:9];
  always_comb begin
    bucket = '0;
    for (int m = 1; m <= 9; m++) begin
      mult[m] = 36'(step_of(step_idx)) * 36'(m);
      if (36'(value) >= mult[m]) bucket = BktBits'(m);
    end
  end
endmodule
`default_nettype wire

[hdl/decimal_bucket_sort_top.sv]
// Top level of the decimal bucket sorter: store, sequencer, insertion sort.
// Depends on dbs_pkg and dbs_bucketer.
// Loading stores each item given with start. On last, a span search over the step sizes
// and a setup state, then an insertion sort on one store port (read, key and compare per
// key, write and compare per shift; O(n^2)), then one result per cycle.
// Reset (synchronous, active low) empties the set; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module decimal_bucket_sort_top import dbs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [31:0]          in_value,
  input  wire logic                 in_last,
  output logic                      out_valid,
  output logic [31:0]               out_sorted_value,
  output logic [3:0]                out_bucket,
  output logic                      out_end_of_set
);
  state_t state_r, state_nxt;
  logic [CntBits-1:0] cnt_r;
  logic [ValueBits-1:0] max_r;
  logic [3:0] sidx_r;
  logic [CntBits-1:0] i_r, pos_r;
  logic [ValueBits-1:0] key_r;
  logic [BktBits-1:0] keyb_r;
  logic [ValueBits-1:0] mem [MaxItems];
  logic [ValueBits-1:0] rd_r;
  logic [IdxBits-1:0] raddr;
  logic [BktBits-1:0] rdb, keyb;
  logic [ValueBits-1:0] vin;
  logic [ValueBits-1:0] bin;

  assign vin = in_value[ValueBits-1:0];
  assign busy = (state_r != ST_LOAD);

  // one shared bucket unit for key and neighbour
  dbs_bucketer u_bkt (.value(bin), .step_idx(sidx_r), .bucket(rdb));
  assign keyb = rdb;
  always_comb begin
    bin = (state_r == ST_KEY) ? rd_r : rd_r;
    raddr = '0;
    case (state_r)
      // prefetch the first entry for output when the sort ends
      ST_RD:   raddr = (i_r >= cnt_r) ? '0 : i_r[IdxBits-1:0];
      ST_KEY:  raddr = IdxBits'(pos_r - 1'b1);
      ST_WR:   raddr = IdxBits'(pos_r - 1'b1);
      ST_EMIT: raddr = IdxBits'(i_r + 1'b1);
      ST_ORD:  raddr = i_r[IdxBits-1:0];
      default: raddr = '0;
    endcase
  end

  logic gt;
  assign gt = (rdb > keyb_r) || ((rdb == keyb_r) && (rd_r > key_r));

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    if (state_r == ST_LOAD && start && cnt_r < CntBits'(MaxItems))
      mem[cnt_r[IdxBits-1:0]] <= vin;
    if (state_r == ST_CMP && pos_r != 0 && gt)
      mem[pos_r[IdxBits-1:0]] <= rd_r;
    if (state_r == ST_CMP && !(pos_r != 0 && gt))
      mem[pos_r[IdxBits-1:0]] <= key_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (start && in_last) state_nxt = ST_SPAN;
      ST_SPAN: if (sidx_r == 4'd9 || 33'(max_r) < 33'(step_of(sidx_r + 4'd1)) * 33'd1
                   || {1'b0, max_r} < {1'b0, step_of(sidx_r + 4'd1)})
                 state_nxt = ST_ORD;
      ST_ORD:  state_nxt = ST_RD;
      ST_RD:   state_nxt = (i_r >= cnt_r) ? ST_EMIT : ST_KEY;
      ST_KEY:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (pos_r != 0 && gt) ? ST_WR : ST_RD;
      ST_WR:   state_nxt = ST_CMP;
      ST_EMIT: if (i_r + 1'b1 >= cnt_r) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // span check: step index k with 10^(k+1) > max, 0 <= k <= 9
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cnt_r <= '0; max_r <= '0; sidx_r <= '0;
      i_r <= '0; pos_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      case (state_r)
        ST_LOAD: if (start) begin
          if (cnt_r < CntBits'(MaxItems)) begin
            cnt_r <= cnt_r + 1'b1;
            if (vin > max_r) max_r <= vin;
          end
          sidx_r <= '0;
        end
        ST_SPAN: begin
          if (state_nxt == ST_SPAN) sidx_r <= sidx_r + 4'd1;
          i_r <= '0;
        end
        ST_ORD: i_r <= CntBits'(1);
        ST_RD: begin
          pos_r <= i_r;
          if (i_r >= cnt_r) i_r <= '0;
        end
        ST_KEY: begin
          key_r <= rd_r;
          keyb_r <= keyb;
        end
        ST_CMP: if (pos_r != 0 && gt) pos_r <= pos_r - 1'b1;
          else i_r <= i_r + 1'b1;
        ST_WR: ;
        ST_EMIT: begin
          out_valid <= (cnt_r != 0);
          out_sorted_value <= rd_r;
          out_bucket <= rdb;
          out_end_of_set <= (i_r + 1'b1 >= cnt_r);
          i_r <= i_r + 1'b1;
          if (i_r + 1'b1 >= cnt_r) begin
            cnt_r <= '0; max_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
